### rtl/core/bba_pkg.sv
package bba_pkg;

	localparam int SLOT_BYTES        = 4096;
	localparam int SLOT_SH           = 12;
	localparam int SLOTS_PER_SECTION = 32;
	localparam int BIT_W             = 5;
	localparam int SECTION_BYTES     = 4 + SLOT_BYTES * SLOTS_PER_SECTION;
	localparam int HEADER_BYTES      = 4;
	localparam int DEF_SECTIONS      = 2;

	localparam int CMD_W      = 2;
	localparam int OFFSET_W   = 20;
	localparam int INDEX_W    = 6;
	localparam int SLOT_OFF_W = 19;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_MARK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

endpackage

### rtl/core/bitmap_block_allocator.sv
// Flow from input transfer to result in the output register: clear and unknown
// commands go straight to push; mark subtracts one section per cycle, then sets the bit;
// alloc scans on from the scan pointer past occupied slots to a free one or the end.
// One item at a time: input ready only while idle; a finished result may wait in the
// output register while the next item is taken. Throughput is set by the scan loop.
// Reset (arst_n low, asynchronous) clears all occupancy bits and rewinds the scan.
module bitmap_block_allocator #(
	parameter int SECTIONS = bba_pkg::DEF_SECTIONS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // mark_offset[19:0], zero fill
	input  logic [1:0]  s_axis_tuser,   // command[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // slot_index[5:0], slot_offset[24:6], zero fill
	output logic [0:0]  m_axis_tuser    // ok[0]
);

	localparam int TOTAL  = SECTIONS * bba_pkg::SLOTS_PER_SECTION;
	localparam int SCAN_W = $clog2(TOTAL + 1);
	localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int CNT_W  = $clog2(SECTIONS + 1);
	localparam int REGION = SECTIONS * bba_pkg::SECTION_BYTES;
	localparam int OFF_W  = $clog2(REGION + bba_pkg::HEADER_BYTES + 1);
	localparam int REM_W  = bba_pkg::OFFSET_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_MARK,
		ST_PUSH
	} state_t;

	state_t                          state_q;
	logic [31:0]                     occ_q [SECTIONS];
	logic [SCAN_W-1:0]               scan_q;
	logic [OFF_W-1:0]                off_q;
	logic [REM_W-1:0]                rem_q;
	logic [CNT_W-1:0]                sec_q;
	logic                            res_ok_q;
	logic [bba_pkg::INDEX_W-1:0]     res_idx_q;
	logic [bba_pkg::SLOT_OFF_W-1:0]  res_off_q;
	logic                            m_valid_q;
	logic                            m_ok_q;
	logic [bba_pkg::INDEX_W-1:0]     m_idx_q;
	logic [bba_pkg::SLOT_OFF_W-1:0]  m_off_q;

	logic [SEC_W-1:0]          scan_sec;
	logic [bba_pkg::BIT_W-1:0] scan_bit;
	logic                      scan_full;
	logic                      slot_busy;
	logic [OFF_W-1:0]          off_step;
	logic [REM_W:0]            rem_diff;
	logic                      rem_ge;
	logic [REM_W-1:0]          rem_m4;
	logic [bba_pkg::BIT_W-1:0] mark_bit;
	logic [SEC_W-1:0]          mark_sec;
	logic                      sec_full;
	bba_pkg::cmd_t             cmd;

	assign cmd       = bba_pkg::cmd_t'(s_axis_tuser);
	assign scan_sec  = scan_q[bba_pkg::BIT_W +: SEC_W];
	assign scan_bit  = scan_q[bba_pkg::BIT_W-1:0];
	assign scan_full = (scan_q == SCAN_W'(TOTAL));
	assign slot_busy = occ_q[scan_sec][scan_bit];
	assign off_step  = (scan_bit == '1) ?
		OFF_W'(bba_pkg::SLOT_BYTES + bba_pkg::HEADER_BYTES) : OFF_W'(bba_pkg::SLOT_BYTES);
	assign rem_diff  = {1'b0, rem_q} - (REM_W+1)'(bba_pkg::SECTION_BYTES);
	assign rem_ge    = !rem_diff[REM_W];
	assign rem_m4    = rem_q - REM_W'(bba_pkg::HEADER_BYTES);
	assign mark_bit  = rem_m4[bba_pkg::SLOT_SH +: bba_pkg::BIT_W];
	assign mark_sec  = sec_q[SEC_W-1:0];
	assign sec_full  = (sec_q == CNT_W'(SECTIONS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			scan_q    <= '0;
			off_q     <= OFF_W'(bba_pkg::HEADER_BYTES);
			for (int i = 0; i < SECTIONS; i++) begin
				occ_q[i] <= '0;
			end
		end else begin
			if (m_axis_tready && state_q != ST_PUSH) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						res_ok_q  <= (cmd == bba_pkg::CMD_CLEAR);
						res_idx_q <= '0;
						res_off_q <= '0;
						case (cmd)
							bba_pkg::CMD_CLEAR: begin
								for (int i = 0; i < SECTIONS; i++) begin
									occ_q[i] <= '0;
								end
								scan_q   <= '0;
								off_q    <= OFF_W'(bba_pkg::HEADER_BYTES);
								state_q  <= ST_PUSH;
							end
							bba_pkg::CMD_ALLOC: begin
								state_q <= ST_ALLOC;
							end
							bba_pkg::CMD_MARK: begin
								rem_q   <= s_axis_tdata[REM_W-1:0];
								sec_q   <= '0;
								state_q <= ST_MARK;
							end
							default: begin
								state_q <= ST_PUSH;
							end
						endcase
					end
				end
				ST_ALLOC: begin
					if (scan_full) begin
						state_q <= ST_PUSH;
					end else if (!slot_busy) begin
						occ_q[scan_sec][scan_bit] <= 1'b1;
						res_ok_q  <= 1'b1;
						res_idx_q <= bba_pkg::INDEX_W'(scan_q);
						res_off_q <= bba_pkg::SLOT_OFF_W'(off_q);
						state_q   <= ST_PUSH;
					end else begin
						scan_q <= scan_q + SCAN_W'(1);
						off_q  <= off_q + off_step;
					end
				end
				ST_MARK: begin
					if (sec_full) begin
						state_q <= ST_PUSH;
					end else if (rem_ge) begin
						rem_q <= rem_diff[REM_W-1:0];
						sec_q <= sec_q + CNT_W'(1);
					end else begin
						if (rem_q >= REM_W'(bba_pkg::HEADER_BYTES)) begin
							occ_q[mark_sec][mark_bit] <= 1'b1;
							res_ok_q <= 1'b1;
						end
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_ok_q    <= res_ok_q;
						m_idx_q   <= res_idx_q;
						m_off_q   <= res_off_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready   = (state_q == ST_IDLE);
	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = {7'b0, m_off_q, m_idx_q};
	assign m_axis_tuser[0] = m_ok_q;

`ifndef ASSERT_OFF
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= SCAN_W'(TOTAL))
		else $error("scan pointer beyond region");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("failed result carries nonzero payload");

	a_push_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_PUSH))
		else $error("result loaded outside push");

	a_alloc_taken: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ALLOC && !scan_full && !slot_busy
		|=> occ_q[$past(scan_sec)][$past(scan_bit)])
		else $error("allocated slot not marked");

	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MARK |-> sec_q <= CNT_W'(SECTIONS))
		else $error("mark section count out of range");
`endif

endmodule
